### sv/axbc_pkg.sv
// Shared types and constants for the axis band classifier.
// No dependencies; every other file refers to it by scoped names.
package axbc_pkg;

    localparam int MAX_BANDS  = 16;
    localparam int BAND_W     = $clog2(MAX_BANDS);
    localparam int COORD_BITS = 32;
    localparam int CNT_W      = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_CLASSIFY = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic REG_AXIS_SELECT  = 1'b0;
    localparam logic REG_BANDS_IN_USE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

### sv/axis_band_classifier.sv
// Axis band classifier: band table, parallel matching and hit counters.
// Depends on axbc_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one item: a band write,
//   a point to classify or a counter clear. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result item per input item.
//   The APB port sets axis_select (0x0) and bands_in_use (0x4); write it
//   only while the block is idle.
// Sequencing
//   An item is matched against all bands in use in the cycle it is accepted and
//   the hit count of the matched band is read from the counter memory; the
//   next cycle does the saturating increment, the write back and loads the
//   output register. No new item is accepted while an item is in the update
//   state, so the read-modify-write of the counter memory completes first.
// Reset and stall
//   Reset empties the band table, zeroes all counters, sets axis_select to
//   2 and bands_in_use to 0. While the receiver stalls, the result holds in
//   the output register and no new item is accepted once it is full.
module axis_band_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_kind,
    input  logic [3:0]                i_entry_slot,
    input  logic signed [31:0]        i_lower_bound,
    input  logic signed [31:0]        i_upper_bound,
    input  logic [7:0]                i_paint_code,
    input  logic signed [31:0]        i_coord_x,
    input  logic signed [31:0]        i_coord_y,
    input  logic signed [31:0]        i_coord_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_matched,
    output logic [3:0]                o_hit_band,
    output logic [7:0]                o_hit_state,
    output logic [31:0]               o_band_hits,
    output logic [31:0]               o_miss_total
);

    localparam int NB = axbc_pkg::MAX_BANDS;
    localparam int BW = axbc_pkg::BAND_W;
    localparam int CW = axbc_pkg::CNT_W;
    localparam int XW = axbc_pkg::COORD_BITS;

    axbc_pkg::t_state r_state, n_state;

    logic [1:0]  r_axis_select;
    logic [4:0]  r_bands_in_use;
    logic        cfg_wr;

    logic signed [XW-1:0] r_band_start [NB];
    logic signed [XW-1:0] r_band_end   [NB];
    logic [7:0]           r_band_paint [NB];

    logic [CW-1:0] mem_hits [NB];
    logic [CW-1:0] r_rd_hits;
    logic [NB-1:0] r_hits_vld;

    logic [1:0]    r_kind;
    logic          r_found;
    logic [BW-1:0] r_band;
    logic [7:0]    r_paint;
    logic [CW-1:0] r_miss, n_miss;

    logic          r_out_valid;
    logic          r_matched;
    logic [3:0]    r_hit_band;
    logic [7:0]    r_hit_state;
    logic [CW-1:0] r_band_hits;
    logic [CW-1:0] r_miss_total;

    logic                 in_accept;
    logic                 load_out;
    logic                 mem_we;
    logic signed [XW-1:0] coord;
    logic [NB-1:0]        band_used, cont_vec, eq_vec, gt_vec;
    logic [BW-1:0]        cont_idx, eq_idx, find_idx;
    logic                 find_ok;
    logic [CW-1:0]        cnt_cur, cnt_next;
    logic                 is_hit;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_select  <= 2'd2;
            r_bands_in_use <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                axbc_pkg::REG_AXIS_SELECT:  r_axis_select  <= pwdata[1:0];
                axbc_pkg::REG_BANDS_IN_USE: r_bands_in_use <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            axbc_pkg::REG_AXIS_SELECT:  prdata = {30'd0, r_axis_select};
            axbc_pkg::REG_BANDS_IN_USE: prdata = {27'd0, r_bands_in_use};
            default:                    prdata = '0;
        endcase
    end

    // Band table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) begin
                r_band_start[i] <= '0;
                r_band_end[i]   <= '0;
                r_band_paint[i] <= '0;
            end
        end else if (in_accept && i_kind == axbc_pkg::KIND_WRITE
                     && 32'(i_entry_slot) < 32'(NB)) begin
            r_band_start[BW'(i_entry_slot)] <= i_lower_bound;
            r_band_end[BW'(i_entry_slot)]   <= i_upper_bound;
            r_band_paint[BW'(i_entry_slot)] <= i_paint_code;
        end
    end

    // Band matching
    always_comb begin
        case (r_axis_select)
            axbc_pkg::AXIS_X: coord = i_coord_x;
            axbc_pkg::AXIS_Y: coord = i_coord_y;
            default:          coord = i_coord_z;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            band_used[i] = 32'(i) < 32'(r_bands_in_use);
            cont_vec[i]  = band_used[i] && coord >= r_band_start[i] && coord < r_band_end[i];
            eq_vec[i]    = band_used[i] && r_band_end[i] == coord;
            gt_vec[i]    = band_used[i] && r_band_end[i] > coord;
        end
    end

    always_comb begin
        cont_idx = '0;
        eq_idx   = '0;
        for (int i = NB - 1; i >= 0; i--) begin
            if (cont_vec[i]) cont_idx = BW'(i);
            if (eq_vec[i])   eq_idx   = BW'(i);
        end
        if (|cont_vec) begin
            find_ok  = 1'b1;
            find_idx = cont_idx;
        end else begin
            find_ok  = ~(|gt_vec) & (|eq_vec);
            find_idx = eq_idx;
        end
    end

    // Item stage
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_kind;
            r_found <= find_ok && i_kind == axbc_pkg::KIND_CLASSIFY;
            r_band  <= find_idx;
            r_paint <= r_band_paint[find_idx];
        end
    end

    // Hit counter memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem_hits[r_band] <= cnt_next;
        if (in_accept) r_rd_hits <= mem_hits[find_idx];
    end

    assign cnt_cur  = r_hits_vld[r_band] ? r_rd_hits : '0;
    assign cnt_next = (cnt_cur == axbc_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
    assign is_hit   = r_kind == axbc_pkg::KIND_CLASSIFY && r_found;

    always_comb begin
        case (r_kind)
            axbc_pkg::KIND_CLASSIFY:
                n_miss = (!r_found && r_miss != axbc_pkg::CNT_MAX) ? r_miss + 1'b1 : r_miss;
            axbc_pkg::KIND_CLEAR:
                n_miss = '0;
            default:
                n_miss = r_miss;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits_vld <= '0;
            r_miss     <= '0;
        end else if (load_out) begin
            r_miss <= n_miss;
            if (r_kind == axbc_pkg::KIND_CLEAR) begin
                r_hits_vld <= '0;
            end else if (mem_we) begin
                r_hits_vld[r_band] <= 1'b1;
            end
        end
    end

    // Sequencer
    always_comb begin
        case (r_state)
            axbc_pkg::ST_IDLE:   n_state = in_accept ? axbc_pkg::ST_UPDATE : axbc_pkg::ST_IDLE;
            axbc_pkg::ST_UPDATE: n_state = axbc_pkg::ST_IDLE;
            default:             n_state = axbc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            axbc_pkg::ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                load_out   = 1'b0;
            end
            axbc_pkg::ST_UPDATE: begin
                o_in_ready = 1'b0;
                load_out   = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
                load_out   = 1'b0;
            end
        endcase
    end

    assign in_accept = i_in_valid && o_in_ready;
    assign mem_we    = load_out && is_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= axbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_matched    <= is_hit;
            r_hit_band   <= is_hit ? 4'(r_band) : '0;
            r_hit_state  <= is_hit ? r_paint : '0;
            r_band_hits  <= is_hit ? cnt_next : '0;
            r_miss_total <= n_miss;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_matched    = r_matched;
    assign o_hit_band   = r_hit_band;
    assign o_hit_state  = r_hit_state;
    assign o_band_hits  = r_band_hits;
    assign o_miss_total = r_miss_total;

    // Checks
    a_update_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == axbc_pkg::ST_UPDATE |-> !r_out_valid)
        else $error("output register full during update");

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == axbc_pkg::ST_UPDATE)
        else $error("accepted item did not enter update");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == axbc_pkg::ST_UPDATE))
        else $error("result without an item in update");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_matched |-> o_hit_band == '0 && o_band_hits == '0)
        else $error("unmatched result carries band data");

endmodule
